// File: sv/fsuit_pkg.sv
`default_nettype none

package fsuit_pkg;

   localparam int KEY_WORDS = 6;
   localparam int LANE_W    = 32;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   typedef logic [11:0] index_type;
   typedef logic [12:0] count_type;

   typedef struct packed {
      logic        command;
      logic [63:0] key_word_0;
      logic [63:0] key_word_1;
      logic [63:0] key_word_2;
      logic [63:0] key_word_3;
      logic [63:0] key_word_4;
      logic [63:0] key_word_5;
   } req_type;

   typedef struct packed {
      index_type unique_index;
      logic      was_new;
      logic      table_full;
      count_type distinct_count;
   } rsp_type;

endpackage

`default_nettype wire

// File: sv/fsuit_fifo.sv
`default_nettype none

module fsuit_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] din,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] dout,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

// File: sv/fsuit_front.sv
`default_nettype none

module fsuit_front #(
   parameter int CAPACITY         = 4096,
   parameter int VECTORS_PER_KEY  = 3,
   parameter int LANES_PER_VECTOR = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire fsuit_pkg::req_type  in_item,
   output logic                     in_ready,
   output logic                     out_push,
   output logic [$clog2(CAPACITY) + VECTORS_PER_KEY * LANES_PER_VECTOR
                 * fsuit_pkg::LANE_W:0] out_item,
   input  wire logic                out_full
);

   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int KEY_BITS = VECTORS_PER_KEY * LANES_PER_VECTOR * fsuit_pkg::LANE_W;
   localparam int MID_W    = 1 + IDX_W + KEY_BITS;
   localparam int NCHUNK   = (KEY_BITS + IDX_W - 1) / IDX_W;

   logic [63:0]              key_word [fsuit_pkg::KEY_WORDS];
   logic [KEY_BITS-1:0]      key_packed;
   logic [NCHUNK*IDX_W-1:0]  key_ext;
   logic [IDX_W-1:0]         fold;
   logic [IDX_W:0]           fold_ext;
   logic [IDX_W-1:0]         hash;
   logic                     stage_valid_ff;
   logic [MID_W-1:0]         stage_item_ff;
   logic                     take;

   assign key_word[0] = in_item.key_word_0;
   assign key_word[1] = in_item.key_word_1;
   assign key_word[2] = in_item.key_word_2;
   assign key_word[3] = in_item.key_word_3;
   assign key_word[4] = in_item.key_word_4;
   assign key_word[5] = in_item.key_word_5;

   // used lanes only, packed densely; word 2v+h holds lanes 2h and 2h+1 of vector v
   for (genvar v = 0; v < VECTORS_PER_KEY; v++) begin : g_vec
      for (genvar l = 0; l < LANES_PER_VECTOR; l++) begin : g_lane
         assign key_packed[(v * LANES_PER_VECTOR + l) * fsuit_pkg::LANE_W +: fsuit_pkg::LANE_W] =
            key_word[2 * v + l / 2][(l % 2) * fsuit_pkg::LANE_W +: fsuit_pkg::LANE_W];
      end
   end

   // xor fold down to a slot number, then one subtract to land below the capacity
   always_comb begin
      key_ext = (NCHUNK * IDX_W)'(key_packed);
      fold    = '0;
      for (int c = 0; c < NCHUNK; c++) begin
         fold = fold ^ key_ext[c * IDX_W +: IDX_W];
      end
      fold_ext = {1'b0, fold};
      if (fold_ext >= (IDX_W + 1)'(CAPACITY)) begin
         hash = IDX_W'(fold_ext - (IDX_W + 1)'(CAPACITY));
      end else begin
         hash = fold;
      end
   end

   assign in_ready = !stage_valid_ff || !out_full;
   assign take     = in_valid && in_ready;
   assign out_push = stage_valid_ff;
   assign out_item = stage_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (take) begin
         stage_valid_ff <= 1'b1;
      end else if (!out_full) begin
         stage_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_item_ff <= {in_item.command, hash, key_packed};
      end
   end

endmodule

`default_nettype wire

// File: sv/fsuit_back.sv
`default_nettype none

module fsuit_back #(
   parameter int CAPACITY = 4096,
   parameter int KEY_BITS = 384
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               q_empty,
   input  wire logic [$clog2(CAPACITY)+KEY_BITS:0] q_item,
   output logic                                    q_pop,
   output logic                                    res_push,
   output fsuit_pkg::rsp_type                      res_item,
   input  wire logic                               res_full,
   output logic                                    sweeping
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int MID_W = 1 + IDX_W + KEY_BITS;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SLOT  = 5'b00010,
      S_KEY   = 5'b00100,
      S_RESP  = 5'b01000,
      S_CLEAR = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                clear_after_ff, clear_after_in;
   logic [IDX_W-1:0]    sweep_ff, sweep_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;
   logic [CNT_W-1:0]    probes_ff, probes_in;
   fsuit_pkg::rsp_type  res_ff, res_in;

   // slot entry: valid bit over the unique index
   logic [IDX_W:0]      slot_mem [CAPACITY];
   logic [IDX_W:0]      slot_q_ff;
   logic [KEY_BITS-1:0] key_mem [CAPACITY];
   logic [KEY_BITS-1:0] key_q_ff;

   logic                q_cmd;
   logic [IDX_W-1:0]    q_hash;
   logic [KEY_BITS-1:0] q_key;
   logic [IDX_W-1:0]    slot_inc;
   logic [CNT_W-1:0]    probes_inc;
   logic                key_hit;
   logic [IDX_W-1:0]    slot_raddr;
   logic                slot_we;
   logic [IDX_W-1:0]    slot_waddr;
   logic [IDX_W:0]      slot_wdata;
   logic                key_we;

   assign q_cmd      = q_item[MID_W-1];
   assign q_hash     = q_item[KEY_BITS +: IDX_W];
   assign q_key      = q_item[KEY_BITS-1:0];
   assign slot_inc   = (slot_ff == IDX_W'(CAPACITY - 1)) ? '0 : slot_ff + IDX_W'(1);
   assign probes_inc = probes_ff + CNT_W'(1);
   assign key_hit    = (key_q_ff == key_ff);
   assign sweeping   = (state_ff == S_CLEAR);
   assign res_item   = res_ff;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      clear_after_in = clear_after_ff;
      sweep_in       = sweep_ff;
      key_in         = key_ff;
      slot_in        = slot_ff;
      probes_in      = probes_ff;
      res_in         = res_ff;
      q_pop          = 1'b0;
      res_push       = 1'b0;
      slot_raddr     = slot_ff;
      slot_we        = 1'b0;
      slot_waddr     = slot_ff;
      slot_wdata     = '0;
      key_we         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            slot_raddr = q_hash;
            if (!q_empty) begin
               q_pop     = 1'b1;
               key_in    = q_key;
               slot_in   = q_hash;
               probes_in = '0;
               if (q_cmd == fsuit_pkg::CMD_CLEAR) begin
                  res_in         = '0;
                  count_in       = '0;
                  clear_after_in = 1'b1;
                  sweep_in       = '0;
                  state_in       = S_RESP;
               end else begin
                  clear_after_in = 1'b0;
                  state_in       = S_SLOT;
               end
            end
         end
         S_SLOT: begin
            if (!slot_q_ff[IDX_W]) begin
               if (count_ff == CNT_W'(CAPACITY)) begin
                  res_in.unique_index   = '0;
                  res_in.was_new        = 1'b0;
                  res_in.table_full     = 1'b1;
                  res_in.distinct_count = fsuit_pkg::count_type'(count_ff);
               end else begin
                  slot_we               = 1'b1;
                  slot_wdata            = {1'b1, count_ff[IDX_W-1:0]};
                  key_we                = 1'b1;
                  count_in              = count_ff + CNT_W'(1);
                  res_in.unique_index   = fsuit_pkg::index_type'(count_ff);
                  res_in.was_new        = 1'b1;
                  res_in.table_full     = 1'b0;
                  res_in.distinct_count = fsuit_pkg::count_type'(count_ff + CNT_W'(1));
               end
               state_in = S_RESP;
            end else begin
               state_in = S_KEY;
            end
         end
         S_KEY: begin
            // read the next slot ahead so a miss goes straight back to the slot check
            slot_raddr = slot_inc;
            if (key_hit) begin
               res_in.unique_index   = fsuit_pkg::index_type'(slot_q_ff[IDX_W-1:0]);
               res_in.was_new        = 1'b0;
               res_in.table_full     = 1'b0;
               res_in.distinct_count = fsuit_pkg::count_type'(count_ff);
               state_in              = S_RESP;
            end else if (probes_inc == CNT_W'(CAPACITY)) begin
               res_in.unique_index   = '0;
               res_in.was_new        = 1'b0;
               res_in.table_full     = 1'b1;
               res_in.distinct_count = fsuit_pkg::count_type'(count_ff);
               state_in              = S_RESP;
            end else begin
               slot_in   = slot_inc;
               probes_in = probes_inc;
               state_in  = S_SLOT;
            end
         end
         S_RESP: begin
            if (!res_full) begin
               res_push = 1'b1;
               state_in = clear_after_ff ? S_CLEAR : S_IDLE;
            end
         end
         S_CLEAR: begin
            slot_we    = 1'b1;
            slot_waddr = sweep_ff;
            slot_wdata = '0;
            sweep_in   = sweep_ff + IDX_W'(1);
            if (sweep_ff == IDX_W'(CAPACITY - 1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         count_ff       <= '0;
         clear_after_ff <= 1'b0;
         sweep_ff       <= '0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         clear_after_ff <= clear_after_in;
         sweep_ff       <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      slot_ff   <= slot_in;
      probes_ff <= probes_in;
      res_ff    <= res_in;
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_q_ff <= slot_mem[slot_raddr];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[count_ff[IDX_W-1:0]] <= key_ff;
      end
      key_q_ff <= key_mem[slot_q_ff[IDX_W-1:0]];
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("distinct count above capacity");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      key_we |-> (count_ff < CNT_W'(CAPACITY)) && slot_we && (state_ff == S_SLOT))
      else $error("insert into a full table");

   a_key_on_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_KEY) |-> slot_q_ff[IDX_W])
      else $error("key compare through an empty slot");

   a_clear_sweeps: assert property (@(posedge clock) disable iff (reset)
      (res_push && clear_after_ff) |=> (state_ff == S_CLEAR) && (sweep_ff == '0)
         && (count_ff == '0))
      else $error("clear result not followed by a sweep");

   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_KEY) |-> (probes_ff < CNT_W'(CAPACITY)))
      else $error("probe count overran the table");
`endif

endmodule

`default_nettype wire

// File: sv/first_seen_unique_id_table_unit.sv
// a home-slot hit passes the front register, mid fifo, slot read, key read and response fifo;
// an insert skips the key read; each further chain probe adds a slot read, then a key read
// the probe fsm takes the next item only after it has pushed the result of the last one
// a clear pushes its result, then sweeps CAPACITY slots, one per cycle, with full high
// reset is synchronous, active high, and starts the same sweep of all slots before any input
`default_nettype none

module first_seen_unique_id_table_unit #(
   parameter int CAPACITY         = 4096,
   parameter int VECTORS_PER_KEY  = 3,
   parameter int LANES_PER_VECTOR = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire fsuit_pkg::req_type req_data,
   input  wire logic               rsp_pop,
   output logic                    rsp_empty,
   output fsuit_pkg::rsp_type      rsp_data
);

   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int KEY_BITS = VECTORS_PER_KEY * LANES_PER_VECTOR * fsuit_pkg::LANE_W;
   localparam int MID_W    = 1 + IDX_W + KEY_BITS;
   localparam int RSP_W    = $bits(fsuit_pkg::rsp_type);

   logic               front_ready;
   logic               sweeping;
   logic               mid_push;
   logic [MID_W-1:0]   mid_din;
   logic               mid_full;
   logic               mid_pop;
   logic [MID_W-1:0]   mid_dout;
   logic               mid_empty;
   logic               res_push;
   fsuit_pkg::rsp_type res_item;
   logic               res_full;
   logic [RSP_W-1:0]   rsp_bits;

   assign req_full = !front_ready || sweeping;
   assign rsp_data = fsuit_pkg::rsp_type'(rsp_bits);

   fsuit_front #(
      .CAPACITY         (CAPACITY),
      .VECTORS_PER_KEY  (VECTORS_PER_KEY),
      .LANES_PER_VECTOR (LANES_PER_VECTOR)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_push && !sweeping),
      .in_item  (req_data),
      .in_ready (front_ready),
      .out_push (mid_push),
      .out_item (mid_din),
      .out_full (mid_full)
   );

   fsuit_fifo #(
      .WIDTH (MID_W),
      .DEPTH (2)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .din   (mid_din),
      .full  (mid_full),
      .pop   (mid_pop),
      .dout  (mid_dout),
      .empty (mid_empty)
   );

   fsuit_back #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (mid_empty),
      .q_item   (mid_dout),
      .q_pop    (mid_pop),
      .res_push (res_push),
      .res_item (res_item),
      .res_full (res_full),
      .sweeping (sweeping)
   );

   fsuit_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (2)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .din   (RSP_W'(res_item)),
      .full  (res_full),
      .pop   (rsp_pop),
      .dout  (rsp_bits),
      .empty (rsp_empty)
   );

endmodule

`default_nettype wire
